[rtl/mbr_pkg.sv]
`default_nettype none

package mbr_pkg;

  localparam int BUFFER_BYTES = 1024;

  localparam int ADDR_W    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int COUNT_W   = $clog2(BUFFER_BYTES + 1);
  localparam int CURSOR_W  = COUNT_W + 3;
  localparam int WIDTH_W   = 16;
  localparam int CMP_W     = (CURSOR_W > WIDTH_W) ? CURSOR_W : WIDTH_W;
  localparam int VALUE_W   = 64;
  localparam int REMAIN_W  = 14;
  localparam int WLEN_W    = 7;
  localparam int ACC_W     = 72;
  localparam int FETCH_W   = 4;
  localparam int MAX_READ_W = 64;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_SKIP    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         byte_in;
    logic [WIDTH_W-1:0] width;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                ok;
    logic                failed;
    logic [REMAIN_W-1:0] rem_bits;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_ALIGN = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[rtl/mbr_align.sv]
`default_nettype none

module mbr_align import mbr_pkg::*; (
  input  logic [ACC_W-1:0]   acc,
  input  logic [2:0]         drop,
  input  logic [WLEN_W-1:0]  wlen,
  output logic [VALUE_W-1:0] value
);

  logic [ACC_W-1:0]   shifted;
  logic [VALUE_W-1:0] mask;

  always_comb begin
    shifted = acc >> drop;
    if (wlen == WLEN_W'(VALUE_W)) begin
      mask = '1;
    end else begin
      mask = (VALUE_W'(1) << wlen) - VALUE_W'(1);
    end
    value = shifted[VALUE_W-1:0] & mask;
  end

endmodule

`default_nettype wire

[rtl/msb_first_bit_reader_top.sv]
// Channel  | Valid      | Stall      | Payload
// input    | in_valid   | in_stall   | in_data  (in_item_t)
// result   | out_valid  | out_stall  | out_data (out_item_t)
//
// Load, skip, restart, a zero-width read and a failing read go from idle straight to result.
// A read that spans bytes first passes the fetch and align states, paced by the buffer
// memory, which returns one byte per cycle on its single registered read port.
// Reset clears the fill count, the cursor and the failure flag; buffer contents are not cleared.
// A new item is taken while the previous result still waits under out_stall.

`default_nettype none

module msb_first_bit_reader_top import mbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   loaded_r, loaded_nxt;
  logic [CURSOR_W-1:0]  cursor_r, cursor_nxt;
  logic                 fail_r, fail_nxt;
  logic [ADDR_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [FETCH_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [FETCH_W-1:0]   rcv_cnt_r, rcv_cnt_nxt;
  logic [FETCH_W-1:0]   nbytes_r, nbytes_nxt;
  logic                 pend_r, pend_nxt;
  logic [2:0]           drop_r, drop_nxt;
  logic [WLEN_W-1:0]    wlen_r, wlen_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [VALUE_W-1:0]   res_value_r, res_value_nxt;
  logic                 res_ok_r, res_ok_nxt;
  out_item_t            out_data_r;
  logic                 out_valid_r;

  logic [7:0]           mem [BUFFER_BYTES];
  logic [7:0]           rd_data_r;
  logic                 mem_we;

  logic [CURSOR_W-1:0]  cap;
  logic [CURSOR_W-1:0]  remaining;
  logic [CMP_W-1:0]     rem_cmp;
  logic [CMP_W-1:0]     w_cmp;
  logic [CMP_W-1:0]     cur_cmp;
  logic [WLEN_W-1:0]    sum_off;
  logic [WLEN_W-1:0]    nb_sum;
  logic                 in_acc;
  logic                 out_free;
  logic [VALUE_W-1:0]   align_value;

  mbr_align u_align (
    .acc   (acc_r),
    .drop  (drop_r),
    .wlen  (wlen_r),
    .value (align_value)
  );

  assign cap       = {loaded_r, 3'b000};
  assign remaining = cap - cursor_r;
  assign rem_cmp   = CMP_W'(remaining);
  assign w_cmp     = CMP_W'(in_data.width);
  assign cur_cmp   = CMP_W'(cursor_r);
  assign sum_off   = WLEN_W'(cursor_r[2:0]) + in_data.width[WLEN_W-1:0];
  assign nb_sum    = sum_off + WLEN_W'(7);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    cursor_nxt    = cursor_r;
    fail_nxt      = fail_r;
    rd_idx_nxt    = rd_idx_r;
    iss_cnt_nxt   = iss_cnt_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    nbytes_nxt    = nbytes_r;
    pend_nxt      = pend_r;
    drop_nxt      = drop_r;
    wlen_nxt      = wlen_r;
    acc_nxt       = acc_r;
    res_value_nxt = res_value_r;
    res_ok_nxt    = res_ok_r;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt = '0;
          res_ok_nxt    = 1'b0;
          state_nxt     = ST_RESP;
          unique case (in_data.op)
            OP_LOAD: begin
              if (loaded_r < COUNT_W'(BUFFER_BYTES)) begin
                mem_we     = 1'b1;
                loaded_nxt = loaded_r + 1'b1;
                res_ok_nxt = 1'b1;
              end
            end
            OP_READ: begin
              if (in_data.width > WIDTH_W'(MAX_READ_W)) begin
                fail_nxt = 1'b1;
              end else if (fail_r || (w_cmp > rem_cmp)) begin
                fail_nxt = 1'b1;
              end else if (in_data.width == '0) begin
                res_ok_nxt = 1'b1;
              end else begin
                wlen_nxt    = in_data.width[WLEN_W-1:0];
                drop_nxt    = 3'd0 - sum_off[2:0];
                nbytes_nxt  = nb_sum[WLEN_W-1:3];
                rd_idx_nxt  = cursor_r[ADDR_W+2:3];
                iss_cnt_nxt = '0;
                rcv_cnt_nxt = '0;
                pend_nxt    = 1'b0;
                acc_nxt     = '0;
                state_nxt   = ST_FETCH;
              end
            end
            OP_SKIP: begin
              if (fail_r || (w_cmp > rem_cmp)) begin
                fail_nxt = 1'b1;
              end else begin
                cursor_nxt = CURSOR_W'(cur_cmp + w_cmp);
                res_ok_nxt = 1'b1;
              end
            end
            OP_RESTART: begin
              loaded_nxt = '0;
              cursor_nxt = '0;
              fail_nxt   = 1'b0;
              res_ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        pend_nxt = 1'b0;
        if (iss_cnt_r != nbytes_r) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          acc_nxt     = {acc_r[ACC_W-9:0], rd_data_r};
          rcv_cnt_nxt = rcv_cnt_r + 1'b1;
          if ((rcv_cnt_r + 1'b1) == nbytes_r) begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        res_value_nxt = align_value;
        res_ok_nxt    = 1'b1;
        cursor_nxt    = cursor_r + CURSOR_W'(wlen_r);
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      loaded_r  <= '0;
      cursor_r  <= '0;
      fail_r    <= 1'b0;
      iss_cnt_r <= '0;
      rcv_cnt_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      cursor_r  <= cursor_nxt;
      fail_r    <= fail_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    nbytes_r    <= nbytes_nxt;
    drop_r      <= drop_nxt;
    wlen_r      <= wlen_nxt;
    acc_r       <= acc_nxt;
    res_value_r <= res_value_nxt;
    res_ok_r    <= res_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[loaded_r[ADDR_W-1:0]] <= in_data.byte_in;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESP) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESP) && out_free) begin
      out_data_r <= '{value: res_value_r, ok: res_ok_r, failed: fail_r,
                      rem_bits: rem_cmp[REMAIN_W-1:0]};
    end
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= cap)
    else $error("bit cursor passed the loaded data");

  a_fetch_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> ((rcv_cnt_r < nbytes_r) && (iss_cnt_r <= nbytes_r)))
    else $error("byte fetch counters out of range");

  a_resp_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESP) && out_free) |=> (out_valid && (state_r == ST_IDLE)))
    else $error("result not handed to the output register");

  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.value == '0))
    else $error("unsuccessful transfer carries a nonzero value");

endmodule

`default_nettype wire
